// ----- sv/gsdo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdo_pkg
// Types, constants and small functions shared by the segment odometer.
// ----------------------------------------------------------------------------
package gsdo_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int SQRT_STEPS   = 34;
   localparam int STEP_W       = 6;
   localparam int SHIFT_W      = 5;

   localparam int LAT_W    = 31;
   localparam int LON_W    = 32;
   localparam int RADIUS_W = 23;
   localparam int SEG_W    = 36;
   localparam int TOTAL_W  = 48;

   localparam logic [24:0] RAD_SCALE    = 25'd31441057;
   localparam logic [33:0] CORDIC_GAIN  = 34'd652032874;
   localparam logic [33:0] PI_Q30       = 34'd3373259426;
   localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
   localparam logic [30:0] ONE_Q30      = 31'd1073741824;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_MEAN, ST_MUL_LON, ST_MUL_LAT, ST_RAD_LAT, ST_CORDIC,
      ST_COS, ST_MUL_EX, ST_RND_EX, ST_SQ_X, ST_SQ_Y, ST_SUM, ST_SQRT,
      ST_MUL_RLO, ST_MUL_RHI, ST_SCALE, ST_DONE
   } gsdo_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MUL_MEAN, OP_MUL_LON, OP_MUL_LAT, OP_RAD_LAT,
      OP_CORDIC, OP_COS, OP_MUL_EX, OP_RND_EX, OP_SQ_X, OP_SQ_Y, OP_SUM,
      OP_SQRT, OP_MUL_RLO, OP_MUL_RHI, OP_SCALE, OP_EMIT
   } gsdo_op_type;

   typedef struct packed {
      gsdo_op_type       op;
      logic [STEP_W-1:0] step;
   } gsdo_cmd_type;

   typedef struct packed {
      logic out_free;
   } gsdo_sts_type;

   function automatic logic [32:0] gsdo_mag(logic signed [32:0] v);
      logic [32:0] r;
      r = v[32] ? 33'(-v) : 33'(v);
      return r;
   endfunction

   function automatic logic [29:0] gsdo_atan(logic [SHIFT_W-1:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0:  r = 30'd843314857;
         5'd1:  r = 30'd497837829;
         5'd2:  r = 30'd263043837;
         5'd3:  r = 30'd133525159;
         5'd4:  r = 30'd67021687;
         5'd5:  r = 30'd33543516;
         5'd6:  r = 30'd16775851;
         5'd7:  r = 30'd8388437;
         5'd8:  r = 30'd4194283;
         5'd9:  r = 30'd2097149;
         5'd31: r = 30'd0;
         default: r = 30'(31'd1 << (5'd30 - idx));
      endcase
      return r;
   endfunction

endpackage

// ----- sv/gsdo_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdo_req_if
// Position pair channel: two points in signed 1e-7 degree units.
// ----------------------------------------------------------------------------
interface gsdo_req_if;
   logic               valid;
   logic               ready;
   logic signed [30:0] first_latitude;
   logic signed [31:0] first_longitude;
   logic signed [30:0] second_latitude;
   logic signed [31:0] second_longitude;

   modport source (output valid, first_latitude, first_longitude, second_latitude,
                   second_longitude, input ready);
   modport sink   (input valid, first_latitude, first_longitude, second_latitude,
                   second_longitude, output ready);
endinterface

// ----- sv/gsdo_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdo_rsp_if
// Result channel: segment length and odometer total in millimetres.
// ----------------------------------------------------------------------------
interface gsdo_rsp_if;
   logic        valid;
   logic        ready;
   logic [35:0] segment_distance_mm;
   logic [47:0] total_distance_mm;

   modport source (output valid, segment_distance_mm, total_distance_mm, input ready);
   modport sink   (input valid, segment_distance_mm, total_distance_mm, output ready);
endinterface

// ----- sv/gsdo_csr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdo_csr_if
// Register write channel carrying the earth radius in metres.
// ----------------------------------------------------------------------------
interface gsdo_csr_if;
   logic        valid;
   logic        ready;
   logic [22:0] earth_radius_m;

   modport source (output valid, earth_radius_m, input ready);
   modport sink   (input valid, earth_radius_m, output ready);
endinterface

// ----- sv/gsdo_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdo_ctrl
// Sequencer: steps the datapath through conversion, CORDIC, root and scale.
// ----------------------------------------------------------------------------
module gsdo_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   gsdo_req_if.sink              req_if,
   input  gsdo_pkg::gsdo_sts_type sts,
   output gsdo_pkg::gsdo_cmd_type cmd
);
   import gsdo_pkg::*;

   gsdo_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_if.valid) state_in = ST_MUL_MEAN;
         ST_MUL_MEAN: state_in = ST_MUL_LON;
         ST_MUL_LON:  state_in = ST_MUL_LAT;
         ST_MUL_LAT:  state_in = ST_RAD_LAT;
         ST_RAD_LAT: begin
            state_in = ST_CORDIC;
            step_in  = '0;
         end
         ST_CORDIC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_COS;
         end
         ST_COS:      state_in = ST_MUL_EX;
         ST_MUL_EX:   state_in = ST_RND_EX;
         ST_RND_EX:   state_in = ST_SQ_X;
         ST_SQ_X:     state_in = ST_SQ_Y;
         ST_SQ_Y:     state_in = ST_SUM;
         ST_SUM: begin
            state_in = ST_SQRT;
            step_in  = '0;
         end
         ST_SQRT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) state_in = ST_MUL_RLO;
         end
         ST_MUL_RLO:  state_in = ST_MUL_RHI;
         ST_MUL_RHI:  state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_DONE;
         ST_DONE:     if (sts.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.step     = step_ff;
      cmd.op       = OP_NONE;
      req_if.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) cmd.op = OP_LOAD;
         end
         ST_MUL_MEAN: cmd.op = OP_MUL_MEAN;
         ST_MUL_LON:  cmd.op = OP_MUL_LON;
         ST_MUL_LAT:  cmd.op = OP_MUL_LAT;
         ST_RAD_LAT:  cmd.op = OP_RAD_LAT;
         ST_CORDIC:   cmd.op = OP_CORDIC;
         ST_COS:      cmd.op = OP_COS;
         ST_MUL_EX:   cmd.op = OP_MUL_EX;
         ST_RND_EX:   cmd.op = OP_RND_EX;
         ST_SQ_X:     cmd.op = OP_SQ_X;
         ST_SQ_Y:     cmd.op = OP_SQ_Y;
         ST_SUM:      cmd.op = OP_SUM;
         ST_SQRT:     cmd.op = OP_SQRT;
         ST_MUL_RLO:  cmd.op = OP_MUL_RLO;
         ST_MUL_RHI:  cmd.op = OP_MUL_RHI;
         ST_SCALE:    cmd.op = OP_SCALE;
         ST_DONE:     if (sts.out_free) cmd.op = OP_EMIT;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

// ----- sv/gsdo_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdo_datapath
// Shared multiplier, CORDIC rotator, digit-serial root and result registers.
// ----------------------------------------------------------------------------
module gsdo_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  gsdo_pkg::gsdo_cmd_type cmd,
   output gsdo_pkg::gsdo_sts_type sts,
   gsdo_req_if.sink               req_if,
   gsdo_rsp_if.source             rsp_if,
   gsdo_csr_if.sink               csr_if
);
   import gsdo_pkg::*;

   logic [RADIUS_W-1:0] radius_ff;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                rsp_valid_ff;
   logic [SEG_W-1:0]    rsp_seg_ff, seg_in;
   logic [TOTAL_W-1:0]  rsp_total_ff;

   logic [32:0]        msum_ff, dlon_ff, dlat_ff;
   logic [67:0]        mul_ff;
   logic [33:0]        radlon_ff, ny_ff, ex_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [30:0]        cos_ff;
   logic [67:0]        sum_ff;
   logic [35:0]        rem_ff;
   logic [33:0]        root_ff;

   logic [33:0]        op_a, op_b;
   logic [32:0]        radius_k;
   logic [58:0]        rnd24_sum;
   logic [33:0]        rad_q;
   logic [30:0]        mean_a;
   logic [33:0]        z_init;
   logic signed [33:0] dx, dy;
   logic [29:0]        atan_v;
   logic [33:0]        x_mag;
   logic [35:0]        rem_cat, trial;
   logic [37:0]        seg_q;
   logic [TOTAL_W:0]   total_sum;
   logic signed [32:0] lat_sum, lat_dif, lon_dif;

   assign csr_if.ready = 1'b1;
   assign sts.out_free = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.segment_distance_mm = rsp_seg_ff;
   assign rsp_if.total_distance_mm   = rsp_total_ff;

   assign lat_sum = 33'(req_if.first_latitude) + 33'(req_if.second_latitude);
   assign lat_dif = 33'(req_if.first_latitude) - 33'(req_if.second_latitude);
   assign lon_dif = 33'(req_if.second_longitude) - 33'(req_if.first_longitude);

   // radius times 1000 by shift and subtract
   assign radius_k = {radius_ff, 10'b0} - 33'({radius_ff, 4'b0})
                   - 33'({radius_ff, 3'b0});

   assign rnd24_sum = mul_ff[58:0] + 59'(1 << 23);
   assign rad_q     = rnd24_sum[57:24];
   assign mean_a    = rad_q[31:1];
   assign z_init    = (mean_a > HALF_PI_Q30) ? (PI_Q30 - 34'(mean_a)) : 34'(mean_a);

   assign dx     = y_ff >>> cmd.step[SHIFT_W-1:0];
   assign dy     = x_ff >>> cmd.step[SHIFT_W-1:0];
   assign atan_v = gsdo_atan(cmd.step[SHIFT_W-1:0]);
   assign x_mag  = x_ff[33] ? 34'(-x_ff) : 34'(x_ff);

   assign rem_cat = {rem_ff[33:0], sum_ff[67:66]};
   assign trial   = {root_ff, 2'b01};

   assign seg_q     = sum_ff[67:30];
   assign seg_in    = (seg_q[37:36] != 2'b00) ? {SEG_W{1'b1}} : seg_q[35:0];
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(seg_in);
   assign total_in  = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.op)
         OP_MUL_MEAN: begin
            op_a = 34'(msum_ff);
            op_b = 34'(RAD_SCALE);
         end
         OP_MUL_LON: begin
            op_a = 34'(dlon_ff);
            op_b = 34'(RAD_SCALE);
         end
         OP_MUL_LAT: begin
            op_a = 34'(dlat_ff);
            op_b = 34'(RAD_SCALE);
         end
         OP_MUL_EX: begin
            op_a = radlon_ff;
            op_b = 34'(cos_ff);
         end
         OP_SQ_X: begin
            op_a = ex_ff;
            op_b = ex_ff;
         end
         OP_SQ_Y: begin
            op_a = ny_ff;
            op_b = ny_ff;
         end
         OP_MUL_RLO: begin
            op_a = 34'(root_ff[16:0]);
            op_b = 34'(radius_k);
         end
         OP_MUL_RHI: begin
            op_a = 34'(root_ff[33:17]);
            op_b = 34'(radius_k);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RESET;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) radius_ff <= csr_if.earth_radius_m;
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
            total_ff     <= total_in;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_MUL_MEAN, OP_MUL_LON, OP_MUL_LAT, OP_MUL_EX, OP_SQ_X, OP_SQ_Y,
         OP_MUL_RLO, OP_MUL_RHI: mul_ff <= op_a * op_b;
         default: ;
      endcase
      case (cmd.op)
         OP_LOAD: begin
            msum_ff <= gsdo_mag(lat_sum);
            dlon_ff <= gsdo_mag(lon_dif);
            dlat_ff <= gsdo_mag(lat_dif);
         end
         OP_MUL_LON: begin
            z_ff <= signed'(z_init);
            x_ff <= signed'(CORDIC_GAIN);
            y_ff <= '0;
         end
         OP_MUL_LAT: radlon_ff <= rad_q;
         OP_RAD_LAT: ny_ff <= rad_q;
         OP_CORDIC: begin
            if (!z_ff[33]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - signed'(34'(atan_v));
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + signed'(34'(atan_v));
            end
         end
         OP_COS: cos_ff <= (x_mag > 34'(ONE_Q30)) ? ONE_Q30 : x_mag[30:0];
         OP_RND_EX: ex_ff <= 34'((mul_ff[63:0] + 64'(1 << 29)) >> 30);
         OP_SQ_Y: sum_ff <= mul_ff;
         OP_SUM: begin
            sum_ff  <= sum_ff + mul_ff;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_SQRT: begin
            // one root bit per step, two radicand bits shifted in
            sum_ff <= {sum_ff[65:0], 2'b00};
            if (rem_cat >= trial) begin
               rem_ff  <= rem_cat - trial;
               root_ff <= {root_ff[32:0], 1'b1};
            end else begin
               rem_ff  <= rem_cat;
               root_ff <= {root_ff[32:0], 1'b0};
            end
         end
         OP_MUL_RHI: sum_ff <= mul_ff + 68'(1 << 29);
         OP_SCALE: sum_ff <= sum_ff + {mul_ff[50:0], 17'b0};
         OP_EMIT: begin
            rsp_seg_ff   <= seg_in;
            rsp_total_ff <= total_in;
         end
         default: ;
      endcase
   end

endmodule

// ----- sv/gps_segment_distance_odometer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_segment_distance_odometer
// Equirectangular segment length between two fixes plus saturating odometer.
// ----------------------------------------------------------------------------
// Sequence from transaction accept to result valid: conversion steps, 24 CORDIC
// rotations, cosine/square/sum steps, 34 root steps, scale steps and the result
// load. A new transaction is accepted only after the previous result is loaded;
// the result register lets the next transaction in while a result waits.
// Reset: odometer total clears to zero, radius returns to 6371000 m.
module gps_segment_distance_odometer (
   input  logic       clock,
   input  logic       reset,
   gsdo_req_if.sink   req_if,
   gsdo_rsp_if.source rsp_if,
   gsdo_csr_if.sink   csr_if
);
   import gsdo_pkg::*;

   gsdo_cmd_type cmd;
   gsdo_sts_type sts;

   gsdo_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .sts    (sts),
      .cmd    (cmd)
   );

   gsdo_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

endmodule
